>>> sv/isots_pkg.sv
// package: types and constants for the timestamp to epoch converter
package isots_pkg;

  typedef enum logic [3:0] {
    PH_YEAR   = 4'd0,
    PH_MONTH  = 4'd1,
    PH_DAY    = 4'd2,
    PH_HOUR   = 4'd3,
    PH_MINUTE = 4'd4,
    PH_SECOND = 4'd5,
    PH_FRAC   = 4'd6,
    PH_ZDIG   = 4'd7,
    PH_ZDONE  = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    ST_PARSE = 3'd0,
    ST_DAYS  = 3'd1,
    ST_MUL   = 3'd2,
    ST_SUM   = 3'd3,
    ST_OUT   = 3'd4
  } ctrl_state_e;

  typedef struct packed {
    logic parse_en;
    logic days_en;
    logic mul_en;
    logic sum_en;
    logic clr;
  } dp_cmd_t;

  typedef struct packed {
    logic last_seen;
    logic ok;
  } dp_status_t;

  localparam int unsigned EpochW = 49;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharDash  = 8'h2d;
  localparam logic [7:0] CharPlus  = 8'h2b;
  localparam logic [7:0] CharColon = 8'h3a;
  localparam logic [7:0] CharDot   = 8'h2e;
  localparam logic [7:0] CharT     = 8'h54;
  localparam logic [7:0] CharZ     = 8'h5a;

endpackage

>>> sv/isots_datapath.sv
// datapath: character parser, range check and epoch arithmetic
module isots_datapath import isots_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  input  logic [7:0]               char_i,
  input  logic                     last_i,
  output dp_status_t               status_o,
  output logic signed [EpochW-1:0] epoch_o
);

  phase_e      phase_q, phase_d;
  logic [2:0]  dig_q, dig_d;
  logic [13:0] year_q, year_d;
  logic [6:0]  mon_q, mon_d, day_q, day_d, hr_q, hr_d, min_q, min_d, sec_q, sec_d;
  logic [9:0]  frac_q, frac_d;
  logic        zneg_q, zneg_d;
  logic [6:0]  zh_q, zh_d, zm_q, zm_d;
  logic        err_q, err_d;
  logic        last_q, ok_q;

  logic        is_dig;
  logic [3:0]  dv;
  logic [2:0]  lead_cnt;
  logic [7:0]  lead_trm;

  assign is_dig = (char_i >= CharZero) && (char_i <= CharNine);
  assign dv     = is_dig ? 4'(char_i - CharZero) : 4'd0;

  always_comb begin
    unique case (phase_q)
      PH_YEAR:  begin lead_cnt = 3'd4; lead_trm = CharDash; end
      PH_MONTH: begin lead_cnt = 3'd2; lead_trm = CharDash; end
      PH_DAY:   begin lead_cnt = 3'd2; lead_trm = CharT; end
      default:  begin lead_cnt = 3'd2; lead_trm = CharColon; end
    endcase
  end

  function automatic logic [13:0] mac(input logic [13:0] a, input logic [3:0] d);
    mac = 14'(a * 14'd10 + 14'(d));
  endfunction

  always_comb begin
    logic zone_ok;
    phase_d = phase_q; dig_d = dig_q; year_d = year_q; mon_d = mon_q; day_d = day_q;
    hr_d = hr_q; min_d = min_q; sec_d = sec_q; frac_d = frac_q; zneg_d = zneg_q;
    zh_d = zh_q; zm_d = zm_q; err_d = err_q;
    zone_ok = 1'b0;
    if (cmd_i.parse_en && !err_q) begin
      if (phase_q <= PH_HOUR || phase_q == PH_MINUTE || phase_q == PH_SECOND ||
          phase_q == PH_FRAC) begin
        if (is_dig) begin
          if (dig_q >= ((phase_q == PH_FRAC) ? 3'd3 : lead_cnt)) begin
            err_d = 1'b1;
          end else begin
            dig_d = dig_q + 3'd1;
            unique case (phase_q)
              PH_YEAR:   year_d = mac(year_q, dv);
              PH_MONTH:  mon_d  = 7'(mac(14'(mon_q), dv));
              PH_DAY:    day_d  = 7'(mac(14'(day_q), dv));
              PH_HOUR:   hr_d   = 7'(mac(14'(hr_q), dv));
              PH_MINUTE: min_d  = 7'(mac(14'(min_q), dv));
              PH_SECOND: sec_d  = 7'(mac(14'(sec_q), dv));
              default:   frac_d = 10'(mac(14'(frac_q), dv));
            endcase
          end
        end else if (phase_q <= PH_HOUR) begin
          if (char_i == lead_trm && dig_q == lead_cnt) begin
            phase_d = phase_e'(phase_q + 4'd1);
            dig_d   = 3'd0;
          end else begin
            err_d = 1'b1;
          end
        end else if (phase_q == PH_FRAC) begin
          if (dig_q == 3'd0) begin
            err_d = 1'b1;
          end else begin
            if (dig_q == 3'd1) frac_d = 10'(frac_q * 10'd100);
            else if (dig_q == 3'd2) frac_d = 10'(frac_q * 10'd10);
            zone_ok = 1'b1;
          end
        end else if (dig_q != 3'd2) begin
          err_d = 1'b1;
        end else if (phase_q == PH_MINUTE && char_i == CharColon) begin
          phase_d = PH_SECOND; dig_d = 3'd0;
        end else if (phase_q == PH_SECOND && char_i == CharDot) begin
          phase_d = PH_FRAC; dig_d = 3'd0;
        end else begin
          zone_ok = 1'b1;
        end
        if (zone_ok) begin
          if (char_i == CharZ) begin
            phase_d = PH_ZDONE; dig_d = 3'd0;
          end else if (char_i == CharPlus || char_i == CharDash) begin
            zneg_d = (char_i == CharDash); phase_d = PH_ZDIG; dig_d = 3'd0;
          end else begin
            err_d = 1'b1;
          end
        end
      end else if (phase_q == PH_ZDIG) begin
        if (!is_dig || dig_q >= 3'd4) begin
          err_d = 1'b1;
        end else begin
          if (dig_q < 3'd2) zh_d = 7'(mac(14'(zh_q), dv));
          else zm_d = 7'(mac(14'(zm_q), dv));
          dig_d = dig_q + 3'd1;
        end
      end else begin
        err_d = 1'b1;
      end
    end
  end

  logic ok_c;
  assign ok_c = !err_d && (phase_d == PH_ZDONE || (phase_d == PH_ZDIG && dig_d == 3'd4))
    && year_d >= 14'd1970 && year_d <= 14'd9999 && mon_d >= 7'd1 && mon_d <= 7'd12
    && day_d >= 7'd1 && day_d <= 7'd31 && hr_d <= 7'd23 && min_d <= 7'd59
    && sec_d <= 7'd59 && zh_d <= 7'd23 && zm_d <= 7'd59;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_YEAR; dig_q <= '0; err_q <= 1'b0; last_q <= 1'b0; ok_q <= 1'b0;
      year_q <= '0; mon_q <= '0; day_q <= '0; hr_q <= '0; min_q <= '0; sec_q <= '0;
      frac_q <= '0; zneg_q <= 1'b0; zh_q <= '0; zm_q <= '0;
    end else if (cmd_i.clr) begin
      phase_q <= PH_YEAR; dig_q <= '0; err_q <= 1'b0; last_q <= 1'b0; ok_q <= 1'b0;
      year_q <= '0; mon_q <= '0; day_q <= '0; hr_q <= '0; min_q <= '0; sec_q <= '0;
      frac_q <= '0; zneg_q <= 1'b0; zh_q <= '0; zm_q <= '0;
    end else if (cmd_i.parse_en) begin
      phase_q <= phase_d; dig_q <= dig_d; err_q <= err_d; year_q <= year_d;
      mon_q <= mon_d; day_q <= day_d; hr_q <= hr_d; min_q <= min_d; sec_q <= sec_d;
      frac_q <= frac_d; zneg_q <= zneg_d; zh_q <= zh_d; zm_q <= zm_d;
      last_q <= last_i; ok_q <= ok_c;
    end
  end

  assign status_o.last_seen = last_q;
  assign status_o.ok        = ok_q;

  // days from civil date, century terms by reciprocal multiply for years up to 9999
  logic [13:0] yy;
  logic [3:0]  mp;
  logic [8:0]  mbase;
  logic [8:0]  doy;
  logic [26:0] yprod;
  logic [13:0] cent;
  logic [21:0] days_q;

  assign yy  = year_q - ((mon_q <= 7'd2) ? 14'd1 : 14'd0);
  assign mp  = (mon_q >= 7'd3) ? 4'(mon_q - 7'd3) : 4'(mon_q + 7'd9);

  // days before each month of a year starting in march
  always_comb begin
    case (mp)
      4'd0:    mbase = 9'd0;
      4'd1:    mbase = 9'd31;
      4'd2:    mbase = 9'd61;
      4'd3:    mbase = 9'd92;
      4'd4:    mbase = 9'd122;
      4'd5:    mbase = 9'd153;
      4'd6:    mbase = 9'd184;
      4'd7:    mbase = 9'd214;
      4'd8:    mbase = 9'd245;
      4'd9:    mbase = 9'd275;
      4'd10:   mbase = 9'd306;
      4'd11:   mbase = 9'd337;
      default: mbase = 9'd0;
    endcase
  end

  assign doy   = 9'(mbase + 9'(day_q) - 9'd1);
  assign yprod = 27'(yy) * 27'd5243;
  assign cent  = 14'(yprod >> 19);

  always_ff @(posedge clk_i) begin
    if (cmd_i.days_en) begin
      days_q <= 22'(yy) * 22'd365 + 22'(yy >> 2) - 22'(cent) + 22'(cent >> 2)
                + 22'(doy) - 22'd719468;
    end
  end

  logic signed [EpochW-1:0] dms_q, tod_q, zone_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      dms_q  <= EpochW'($signed({1'b0, days_q}) * 49'sd86400000);
      tod_q  <= EpochW'(hr_q * 32'd3600000 + min_q * 32'd60000 + sec_q * 32'd1000
                + 32'(frac_q));
      zone_q <= EpochW'(zh_q * 32'd3600000 + zm_q * 32'd60000);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_en) begin
      if (!ok_q) epoch_o <= '0;
      else if (zneg_q && zh_q != 7'd0) epoch_o <= dms_q + tod_q + zone_q;
      else epoch_o <= dms_q + tod_q - zone_q;
    end
  end

endmodule

>>> sv/isots_ctrl.sv
// controller: sequences parsing, conversion steps and result hand-off
module isots_ctrl import isots_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_fire_i,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       in_ready_o,
  output logic       out_valid_o
);

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_PARSE: if (status_i.last_seen) state_d = ST_DAYS;
      ST_DAYS:  state_d = ST_MUL;
      ST_MUL:   state_d = ST_SUM;
      ST_SUM:   state_d = ST_OUT;
      ST_OUT:   if (out_ready_i) state_d = ST_PARSE;
      default:  state_d = ST_PARSE;
    endcase
  end

  // last_seen is checked the cycle after the last transfer
  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_PARSE: begin
        in_ready_o = !status_i.last_seen;
        cmd_o.parse_en = in_fire_i;
      end
      ST_DAYS:  cmd_o.days_en = 1'b1;
      ST_MUL:   cmd_o.mul_en = 1'b1;
      ST_SUM:   cmd_o.sum_en = 1'b1;
      ST_OUT: begin
        out_valid_o = 1'b1;
        cmd_o.clr = out_ready_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_PARSE;
    else         state_q <= state_d;
  end

endmodule

>>> sv/iso8601_timestamp_to_epoch_millis.sv
// top level: iso 8601 timestamp string to utc epoch milliseconds
// One character is taken per transfer, one per cycle while a string is read. After the
// transfer with tlast the block steps through end-of-string check, calendar day count,
// multiply, sum and result, and holds the result until taken; the next string starts
// the cycle after that transfer.
module iso8601_timestamp_to_epoch_millis import isots_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // char_code
  input  logic        s_axis_tlast,  // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // valid_res, epoch_millis, zero fill
  output logic        m_axis_tlast
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_fire;
  logic signed [EpochW-1:0] epoch;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  isots_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .out_ready_i(m_axis_tready),
    .status_i(status), .cmd_o(cmd), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid)
  );

  isots_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .char_i(s_axis_tdata), .last_i(s_axis_tlast),
    .status_o(status), .epoch_o(epoch)
  );

  assign m_axis_tdata = {6'd0, epoch, status.ok};
  assign m_axis_tlast = 1'b1;

  a_no_in_when_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result pending");
  a_zero_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> m_axis_tdata[49:1] == '0)
    else $error("invalid result not zero");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tlast) |=> !s_axis_tready) else $error("ready after last");

endmodule
